// File: rtl/tsvf_pkg.sv
// ============================================================================
// tsvf_pkg
// Shared widths, fixed-point constants, codes and sequencer states for the
// trapezoidal state variable filter.
// ============================================================================
package tsvf_pkg;

  // word field widths
  localparam int SAMPLE_W   = 24;
  localparam int CUTOFF_W   = 17;
  localparam int Q_W        = 16;
  localparam int SRATE_W    = 18;
  localparam int MODE_W     = 2;

  // state format Q4.28, samples enter left-shifted into it
  localparam int STATE_FRAC      = 28;
  localparam int STATE_WIDTH_DEF = 32;
  localparam int XSH             = STATE_FRAC - SAMPLE_W + 1;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SRATE_W;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 1'd1;

  localparam logic [SRATE_W-1:0] SRATE_RESET = 18'd48000;

  // response select
  localparam logic [MODE_W-1:0] MODE_LP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BP = 2'd2;

  // fixed-point constants
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [31:0] PI_Q30    = 32'd3373259426;
  localparam logic [23:0] R_HALF    = 24'h80_0000;
  localparam logic [22:0] R_QUARTER = 23'h40_0000;
  localparam logic [22:0] R_MAX     = 23'd8220835;

  // sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDIV,   // r = (fc << 24) / fs
    ST_ANG,    // angle = r * pi
    ST_X2,     // angle squared
    ST_TDIV,   // Horner term divide, as a reciprocal multiply
    ST_TMUL,   // Horner term multiply
    ST_SMUL,   // sin = x * t
    ST_SQ,     // ss, cc, sc
    ST_CMUL,   // coefficient numerator * q
    ST_CDIV,   // coefficient divide
    ST_FMUL,   // integrator products
    ST_KDIV,   // k * v1
    ST_MIX     // response mix, output load
  } state_t;

  // Horner divisors d (sine terms 72, 42, 20, 6, then cosine terms 90, 56,
  // 30, 12, 2) as M = ceil(2^S / d) with S = 30 + ceil(log2 d); for any
  // dividend below 2^30, (n * M) >> S equals floor(n / d)
  function automatic logic [30:0] tdiv_recip(input logic [3:0] idx);
    logic [30:0] m;
    case (idx)
      4'd0:    m = 31'd1908874354;
      4'd1:    m = 31'd1636178018;
      4'd2:    m = 31'd1717986919;
      4'd3:    m = 31'd1431655766;
      4'd4:    m = 31'd1527099484;
      4'd5:    m = 31'd1227133514;
      4'd6:    m = 31'd1145324613;
      4'd7:    m = 31'd1431655766;
      4'd8:    m = 31'd1073741824;
      default: m = 31'd0;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] tdiv_shift(input logic [3:0] idx);
    logic [5:0] sh;
    case (idx)
      4'd0:    sh = 6'd37;
      4'd1:    sh = 6'd36;
      4'd2:    sh = 6'd35;
      4'd3:    sh = 6'd33;
      4'd4:    sh = 6'd37;
      4'd5:    sh = 6'd36;
      4'd6:    sh = 6'd35;
      4'd7:    sh = 6'd34;
      default: sh = 6'd31;
    endcase
    return sh;
  endfunction

endpackage

// File: rtl/tsvf_if.sv
// ============================================================================
// tsvf_if
// Valid/ready channels carrying filter input and output words.
// ============================================================================
interface tsvf_in_if import tsvf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [CUTOFF_W-1:0]        cutoff_hz;
  logic [Q_W-1:0]             q_amount;
  logic                       last_in;

  modport source (output valid, sample_in, cutoff_hz, q_amount, last_in, input ready);
  modport sink   (input valid, sample_in, cutoff_hz, q_amount, last_in, output ready);
endinterface

interface tsvf_out_if import tsvf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       last_out;

  modport source (output valid, sample_out, last_out, input ready);
  modport sink   (input valid, sample_out, last_out, output ready);
endinterface

// File: rtl/trapezoidal_state_variable_filter.sv
// ============================================================================
// trapezoidal_state_variable_filter
// Per-sample tuned two-integrator trapezoidal SVF on one shared multiplier
// and one shared restoring divider.
// ============================================================================
// One input word carries a Q1.23 sample, its own cutoff in Hz and Q in 1/256
// units; one output word comes back per input. Each word walks a sequencer
// through 5 divides on a one-bit-per-cycle restoring divider (DW = 62 at
// the default state width) and 29 multiplies on a single registered
// multiplier; the nine Horner divides by constants run on the multiplier as
// reciprocal products. A word still waiting downstream holds the sequencer
// in its last step. Input ready is high only while the sequencer idles; the
// output register lets the next word be accepted while a finished word
// waits downstream. The user must write sample_rate and mode through the
// plain write port only while no word is in flight; the block does not
// enforce it.
// ============================================================================
module trapezoidal_state_variable_filter import tsvf_pkg::*; #(
  parameter int STATE_WIDTH = STATE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  tsvf_in_if.sink               in_ch,
  tsvf_out_if.source            out_ch,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // datapath widths
  localparam int XW  = SAMPLE_W + XSH;                           // scaled input
  localparam int VW  = ((STATE_WIDTH > XW) ? STATE_WIDTH : XW) + 1; // v3
  localparam int MAW = 33;                                        // mult port a
  localparam int MBW = (VW > 33) ? VW : 33;                       // mult port b
  localparam int PW  = MAW + MBW;                                 // product
  localparam int VAW = PW - 29;                                   // v1
  localparam int DW0 = VAW + 8;
  localparam int DW  = (DW0 > 62) ? DW0 : 62;                     // dividend
  localparam int DVW = 34;                                        // divisor
  localparam int CW  = $clog2(DW);
  localparam int EW  = VAW + 3;                                   // 2v - ic
  localparam int YW  = VAW + 11;                                  // mix

  // sequencer
  state_t          state, state_next;
  logic            ph;       // 0: issue / load, 1: consume / iterate
  logic [1:0]      step;
  logic [3:0]      tidx;
  logic [CW-1:0]   dcnt;

  // configuration and filter state
  logic [SRATE_W-1:0]          sample_rate;
  logic [MODE_W-1:0]           mode;
  logic signed [STATE_WIDTH-1:0] ic1, ic2;

  // captured word
  logic signed [XW-1:0] x;
  logic [CUTOFF_W-1:0]  fc;
  logic [Q_W-1:0]       q;
  logic                 last;

  // tuning values
  logic [22:0] ang_base;
  logic        fold;
  logic [30:0] xa, x2, t, tmp, s_raw, ss, cc, sc, a1, a2, a3;
  logic [30:0] sv, cv;
  logic [30:0] tquo;
  logic [45:0] cm;
  logic [DVW-1:0] den;

  // filter values
  logic signed [PW-1:0]  prod;
  logic signed [PW:0]    acc, acc_sum;
  logic signed [VAW-1:0] v1;
  logic [VAW-1:0]        v1_mag;
  logic signed [VAW:0]   v2;
  logic signed [VAW+8:0] kv1;
  logic signed [VW-1:0]  v3;
  logic signed [EW-1:0]  e1, e2;
  logic signed [STATE_WIDTH-1:0] ic1_next, ic2_next;
  logic signed [YW-1:0]  y;
  logic signed [SAMPLE_W-1:0] y_sat;

  // shared multiplier operands
  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;

  // shared divider
  logic [DW-1:0]  div_quo, div_quo_next, div_dvd;
  logic [DVW-1:0] div_rem, div_rem_next, div_dvs;
  logic [DVW-1:0] div_dvs_q;
  logic [DVW:0]   div_shift;
  logic           div_ge;
  logic           div_last;
  logic [22:0]    r_clamp;
  logic           is_div;

  // output register
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_last;
  logic                       out_free;
  logic                       in_acc;

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_acc) state_next = ST_RDIV;
      ST_RDIV: if (ph && div_last) state_next = ST_ANG;
      ST_ANG:  if (ph) state_next = ST_X2;
      ST_X2:   if (ph) state_next = ST_TDIV;
      ST_TDIV: begin
        if (ph) begin
          if (tidx == 4'd3)      state_next = ST_SMUL;  // sine chain done
          else if (tidx == 4'd8) state_next = ST_SQ;    // cosine chain done
          else                   state_next = ST_TMUL;
        end
      end
      ST_TMUL: if (ph) state_next = ST_TDIV;
      ST_SMUL: if (ph) state_next = ST_TDIV;
      ST_SQ:   if (ph && step == 2'd2) state_next = ST_CMUL;
      ST_CMUL: if (ph) state_next = ST_CDIV;
      ST_CDIV: begin
        if (ph && div_last) state_next = (step == 2'd2) ? ST_FMUL : ST_CMUL;
      end
      ST_FMUL: if (ph && step == 2'd3) state_next = ST_KDIV;
      ST_KDIV: if (ph && div_last) state_next = ST_MIX;
      ST_MIX:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // outputs of the sequencer: handshake and shared unit operands
  // --------------------------------------------------------------------------
  always_comb begin
    in_ch.ready = (state == ST_IDLE);
    is_div      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_dvd     = '0;
    div_dvs     = '0;
    unique case (state)
      ST_RDIV: begin
        is_div  = 1'b1;
        div_dvd = DW'({fc, 24'b0});
        div_dvs = DVW'(sample_rate);
      end
      ST_ANG: begin
        mul_a = MAW'(PI_Q30);
        mul_b = MBW'(ang_base);
      end
      ST_X2: begin
        mul_a = MAW'(xa);
        mul_b = MBW'(xa);
      end
      ST_TDIV: begin
        mul_a = MAW'(tdiv_recip(tidx));
        mul_b = MBW'((tidx == 4'd0 || tidx == 4'd4) ? x2 : tmp);
      end
      ST_TMUL: begin
        mul_a = MAW'(x2);
        mul_b = MBW'(t);
      end
      ST_SMUL: begin
        mul_a = MAW'(xa);
        mul_b = MBW'(t);
      end
      ST_SQ: begin
        mul_a = MAW'((step == 2'd1) ? cv : sv);
        mul_b = MBW'((step == 2'd0) ? sv : cv);
      end
      ST_CMUL: begin
        mul_a = MAW'((step == 2'd0) ? cc : ((step == 2'd1) ? sc : ss));
        mul_b = MBW'(q);
      end
      ST_CDIV: begin
        is_div  = 1'b1;
        div_dvd = DW'({cm, 16'b0});
        div_dvs = den;
      end
      ST_FMUL: begin
        mul_a = MAW'((step == 2'd0) ? a1 : ((step == 2'd3) ? a3 : a2));
        mul_b = step[0] ? MBW'(v3) : MBW'(ic1);
      end
      ST_KDIV: begin
        is_div  = 1'b1;
        div_dvd = DW'({v1_mag, 8'b0});
        div_dvs = DVW'(q);
      end
      default: ;
    endcase
  end

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;

  // --------------------------------------------------------------------------
  // combinational datapath pieces
  // --------------------------------------------------------------------------
  // fold above a quarter swaps sin and cos
  assign sv  = fold ? t : s_raw;
  assign cv  = fold ? s_raw : t;
  assign den = {2'b0, q, 16'b0} + DVW'(sc[30:6]);
  assign v3  = VW'(x) - VW'(ic2);

  // Horner quotient from the reciprocal product
  assign tquo = 31'($unsigned(prod) >> tdiv_shift(tidx));

  assign acc_sum = acc + (PW+1)'(prod);
  assign v1_mag  = v1[VAW-1] ? VAW'(-v1) : VAW'(v1);

  // restoring divide, one quotient bit per cycle
  assign div_shift    = {div_rem, div_quo[DW-1]};
  assign div_ge       = (div_shift >= {1'b0, div_dvs_q});
  assign div_rem_next = div_ge ? DVW'(div_shift - {1'b0, div_dvs_q}) : DVW'(div_shift);
  assign div_quo_next = {div_quo[DW-2:0], div_ge};
  assign div_last     = (dcnt == CW'(DW-1));
  assign r_clamp      = (div_quo_next > DW'(R_MAX)) ? R_MAX : div_quo_next[22:0];

  // integrator update, saturated to the state width
  assign e1 = (EW'(v1) <<< 1) - EW'(ic1);
  assign e2 = (EW'(v2) <<< 1) - EW'(ic2);
  assign ic1_next = ((e1[EW-1:STATE_WIDTH-1] == '0) || (e1[EW-1:STATE_WIDTH-1] == '1)) ?
                    e1[STATE_WIDTH-1:0] : {e1[EW-1], {(STATE_WIDTH-1){~e1[EW-1]}}};
  assign ic2_next = ((e2[EW-1:STATE_WIDTH-1] == '0) || (e2[EW-1:STATE_WIDTH-1] == '1)) ?
                    e2[STATE_WIDTH-1:0] : {e2[EW-1], {(STATE_WIDTH-1){~e2[EW-1]}}};

  // response mix; an unused mode code falls back to low-pass
  always_comb begin
    case (mode)
      MODE_HP: y = YW'(x) - YW'(kv1) - YW'(v2);
      MODE_BP: y = YW'(kv1);
      default: y = YW'(v2);
    endcase
  end

  // floor to Q1.23 then saturate
  assign y_sat = ((y[YW-1:XSH+SAMPLE_W-1] == '0) || (y[YW-1:XSH+SAMPLE_W-1] == '1)) ?
                 y[XSH+SAMPLE_W-1:XSH] : {y[YW-1], {(SAMPLE_W-1){~y[YW-1]}}};

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ph    <= 1'b0;
      step  <= '0;
      tidx  <= '0;
      dcnt  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        ph   <= 1'b0;
        step <= '0;
        tidx <= '0;
      end else if (is_div) begin
        if (!ph) begin
          ph   <= 1'b1;
          dcnt <= '0;
        end else if (div_last) begin
          ph <= 1'b0;
          if (state == ST_CDIV) step <= (step == 2'd2) ? 2'd0 : step + 2'd1;
        end else begin
          dcnt <= dcnt + CW'(1);
        end
      end else if (state != ST_MIX) begin
        ph <= ~ph;
        if (ph && state == ST_TDIV) tidx <= tidx + 4'd1;
        if (ph && state == ST_SQ)   step <= (step == 2'd2) ? 2'd0 : step + 2'd1;
        if (ph && state == ST_FMUL) step <= step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= SRATE_RESET;
      mode        <= MODE_LP;
      ic1         <= '0;
      ic2         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          REG_SAMPLE_RATE: sample_rate <= cfg_data;
          REG_MODE:        mode <= cfg_data[MODE_W-1:0];
          default: ;
        endcase
      end
      // integrators move once v1 and v2 are settled
      if (state == ST_KDIV && !ph) begin
        ic1 <= ic1_next;
        ic2 <= ic2_next;
      end
      if (state == ST_MIX && out_free) out_valid <= 1'b1;
      else if (out_ch.ready)           out_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (in_acc) begin
      x    <= XW'(in_ch.sample_in) <<< XSH;
      fc   <= in_ch.cutoff_hz;
      q    <= (in_ch.q_amount == '0) ? Q_W'(1) : in_ch.q_amount;
      last <= in_ch.last_in;
    end

    if (is_div) begin
      if (!ph) begin
        div_quo   <= div_dvd;
        div_rem   <= '0;
        div_dvs_q <= div_dvs;
      end else begin
        div_quo <= div_quo_next;
        div_rem <= div_rem_next;
      end
    end

    case (state)
      ST_RDIV: begin
        if (ph && div_last) begin
          fold     <= (r_clamp > R_QUARTER);
          ang_base <= (r_clamp > R_QUARTER) ? 23'(R_HALF - {1'b0, r_clamp}) : r_clamp;
        end
      end
      ST_ANG:  if (ph) xa <= prod[54:24];
      ST_X2:   if (ph) x2 <= prod[60:30];
      ST_TDIV: if (ph) t <= ONE_Q30 - tquo;
      ST_TMUL: if (ph) tmp <= prod[60:30];
      ST_SMUL: if (ph) s_raw <= prod[60:30];
      ST_SQ: begin
        if (ph) begin
          case (step)
            2'd0:    ss <= prod[60:30];
            2'd1:    cc <= prod[60:30];
            default: sc <= prod[60:30];
          endcase
        end
      end
      ST_CMUL: if (ph) cm <= prod[45:0];
      ST_CDIV: begin
        if (ph && div_last) begin
          case (step)
            2'd0:    a1 <= div_quo_next[30:0];
            2'd1:    a2 <= div_quo_next[30:0];
            default: a3 <= div_quo_next[30:0];
          endcase
        end
      end
      ST_FMUL: begin
        if (ph) begin
          case (step)
            2'd0, 2'd2: acc <= (PW+1)'(prod);
            2'd1:       v1 <= $signed(acc_sum[PW:30]);
            default:    v2 <= (VAW+1)'(ic2) + (VAW+1)'($signed(acc_sum[PW:30]));
          endcase
        end
      end
      ST_KDIV: begin
        if (ph && div_last) begin
          kv1 <= v1[VAW-1] ? -$signed({1'b0, div_quo_next[VAW+7:0]})
                           :  $signed({1'b0, div_quo_next[VAW+7:0]});
        end
      end
      ST_MIX: begin
        if (out_free) begin
          out_sample <= y_sat;
          out_last   <= last;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = out_sample;
  assign out_ch.last_out   = out_last;

endmodule
